@@ design/ptr_pkg.sv @@
package ptr_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_REFRESHED = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_FULL      = 3'd2,
      ST_ROUTE     = 3'd3,
      ST_NOROUTE   = 3'd4
   } status_type;

   typedef enum logic {
      CMD_HEARTBEAT = 1'b0,
      CMD_ROUTE     = 1'b1
   } command_type;

   typedef struct packed {
      logic        command;
      logic [63:0] id_word0;
      logic [63:0] id_word1;
      logic [63:0] id_word2;
      logic [63:0] id_word3;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [63:0] peer_word0;
      logic [63:0] peer_word1;
      logic [63:0] peer_word2;
      logic [63:0] peer_word3;
      logic [63:0] peer_addr_high;
      logic [63:0] peer_addr_low;
      logic [63:0] peer_seen_ms;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_WRITE,
      FSM_READ,
      FSM_BUILD,
      FSM_RESULT
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request, clear scan
      logic scan;      // compare one entry, advance pointer
      logic write;     // perform heartbeat store update
      logic read;      // read chosen entry
      logic finish;    // build result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic is_route;
      logic do_write;
   } sts_type;

endpackage

@@ design/ptr_datapath.sv @@
module ptr_datapath #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  ptr_pkg::req_type req_data,
   input  ptr_pkg::cmd_type cmd,
   output ptr_pkg::sts_type sts,
   output ptr_pkg::rsp_type rsp_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // entry storage; memories carry no reset
   logic [255:0] id_mem   [TABLE_DEPTH];
   logic [127:0] addr_mem [TABLE_DEPTH];
   logic [63:0]  seen_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   ptr_pkg::req_type req_ff;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          match_ff, match_in;
   logic          free_ff, free_in;
   logic          found_ff, found_in;
   logic [AW-1:0] hit_ff, hit_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [7:0]    dist_ff, dist_in;
   logic [255:0]  rd_id_ff;
   logic [127:0]  rd_addr_ff;
   logic [63:0]   rd_seen_ff;
   ptr_pkg::rsp_type rsp_ff, rsp_in;

   logic [255:0] scan_id_ff;
   logic         scan_vld_ff;
   logic [AW-1:0] scan_idx_ff;
   logic         scan_act_ff;
   logic [7:0]   d;
   logic [255:0] req_id;

   assign req_id = {req_ff.id_word0, req_ff.id_word1, req_ff.id_word2, req_ff.id_word3};

   // scan read stage: registered memory read then compare
   always_ff @(posedge clock) begin
      scan_id_ff  <= id_mem[ptr_ff];
      scan_vld_ff <= valid_ff[ptr_ff];
      scan_idx_ff <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff <= 1'b0;
      end else begin
         scan_act_ff <= cmd.scan;
      end
   end

   assign d = scan_id_ff[255:248] ^ req_ff.id_word0[63:56];

   // compare one entry per cycle
   always_comb begin
      ptr_in      = ptr_ff;
      match_in    = match_ff;
      free_in     = free_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      free_idx_in = free_idx_ff;
      dist_in     = dist_ff;
      if (cmd.load) begin
         ptr_in   = '0;
         match_in = 1'b0;
         free_in  = 1'b0;
         found_in = 1'b0;
      end else begin
         if (cmd.scan) begin
            ptr_in = ptr_ff + AW'(1);
         end
         if (scan_act_ff) begin
            if (scan_vld_ff) begin
               if (req_ff.command == ptr_pkg::CMD_ROUTE) begin
                  if (!found_ff || d < dist_ff) begin
                     found_in = 1'b1;
                     dist_in  = d;
                     hit_in   = scan_idx_ff;
                  end
               end else if (!match_ff && scan_id_ff == req_id) begin
                  match_in = 1'b1;
                  hit_in   = scan_idx_ff;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_idx_in = scan_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff   <= '0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         ptr_ff   <= ptr_in;
         match_ff <= match_in;
         free_ff  <= free_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      hit_ff      <= hit_in;
      free_idx_ff <= free_idx_in;
      dist_ff     <= dist_in;
   end

   // heartbeat update
   always_ff @(posedge clock) begin
      if (cmd.write && req_ff.command == ptr_pkg::CMD_HEARTBEAT) begin
         if (match_ff) begin
            seen_mem[hit_ff] <= req_ff.time_ms;
         end else if (free_ff) begin
            id_mem[free_idx_ff]   <= req_id;
            addr_mem[free_idx_ff] <= {req_ff.addr_high, req_ff.addr_low};
            seen_mem[free_idx_ff] <= req_ff.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write && req_ff.command == ptr_pkg::CMD_HEARTBEAT
                   && !match_ff && free_ff) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end
   end

   // registered read of chosen entry
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_id_ff   <= id_mem[hit_ff];
         rd_addr_ff <= addr_mem[hit_ff];
         rd_seen_ff <= seen_mem[hit_ff];
      end
   end

   // result build
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in = '0;
         if (req_ff.command == ptr_pkg::CMD_ROUTE) begin
            if (found_ff) begin
               rsp_in.status         = ptr_pkg::ST_ROUTE;
               rsp_in.entry_index    = 6'(hit_ff);
               rsp_in.peer_word0     = rd_id_ff[255:192];
               rsp_in.peer_word1     = rd_id_ff[191:128];
               rsp_in.peer_word2     = rd_id_ff[127:64];
               rsp_in.peer_word3     = rd_id_ff[63:0];
               rsp_in.peer_addr_high = rd_addr_ff[127:64];
               rsp_in.peer_addr_low  = rd_addr_ff[63:0];
               rsp_in.peer_seen_ms   = rd_seen_ff;
            end else begin
               rsp_in.status = ptr_pkg::ST_NOROUTE;
            end
         end else if (match_ff) begin
            rsp_in.status      = ptr_pkg::ST_REFRESHED;
            rsp_in.entry_index = 6'(hit_ff);
         end else if (free_ff) begin
            rsp_in.status      = ptr_pkg::ST_INSERTED;
            rsp_in.entry_index = 6'(free_idx_ff);
         end else begin
            rsp_in.status = ptr_pkg::ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data      = rsp_ff;
   assign sts.scan_last = (ptr_ff == AW'(TABLE_DEPTH - 1));
   assign sts.is_route  = (req_ff.command == ptr_pkg::CMD_ROUTE);
   assign sts.do_write  = 1'b1;

endmodule

@@ design/ptr_control.sv @@
module ptr_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ptr_pkg::sts_type sts,
   output ptr_pkg::cmd_type cmd
);

   ptr_pkg::fsm_type state_ff, state_in;
   logic             drain_ff, drain_in;
   logic             rsp_valid_ff;

   // next state; drain waits for the last compare
   always_comb begin
      state_in = state_ff;
      drain_in = 1'b0;
      case (state_ff)
         ptr_pkg::FSM_IDLE: begin
            if (req_valid) state_in = ptr_pkg::FSM_SCAN;
         end
         ptr_pkg::FSM_SCAN: begin
            if (drain_ff) begin
               state_in = sts.is_route ? ptr_pkg::FSM_READ : ptr_pkg::FSM_WRITE;
            end else if (sts.scan_last) begin
               drain_in = 1'b1;
            end
         end
         ptr_pkg::FSM_WRITE:  state_in = ptr_pkg::FSM_READ;
         ptr_pkg::FSM_READ:   state_in = ptr_pkg::FSM_BUILD;
         ptr_pkg::FSM_BUILD:  state_in = ptr_pkg::FSM_RESULT;
         ptr_pkg::FSM_RESULT: begin
            if (rsp_valid && !rsp_stall) state_in = ptr_pkg::FSM_IDLE;
         end
         default: state_in = ptr_pkg::FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptr_pkg::FSM_IDLE;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
      end
   end

   // result valid rises with the built result and holds until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ptr_pkg::FSM_BUILD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ptr_pkg::FSM_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ptr_pkg::FSM_SCAN:  cmd.scan   = !drain_ff;
         ptr_pkg::FSM_WRITE: cmd.write  = sts.do_write;
         ptr_pkg::FSM_READ:  cmd.read   = 1'b1;
         ptr_pkg::FSM_BUILD: cmd.finish = 1'b1;
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // requests are taken only when idle
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ptr_pkg::FSM_IDLE) |-> req_stall);

   // a result is offered only in the result state
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ptr_pkg::FSM_RESULT));

   // a stalled result stays offered
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid);

   // at most one command per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd));

endmodule

@@ design/peer_table_heartbeat_and_route.sv @@
// channel | direction | payload
// req     | in        | ptr_pkg::req_type (command, identity, address, time)
// rsp     | out       | ptr_pkg::rsp_type (status, entry, chosen peer)
// A heartbeat passes the scan, write, read, build and result states before the next acceptance;
// a route skips the write state. The table scan compares one entry per cycle.
// The result is offered in the result state, after the build state has registered it.
// Reset clears the valid marks and the controller at once; no clearing pass.
// req_stall is high while a transaction is in work or its result waits.
// rsp_valid holds with its payload until rsp_stall is low.
module peer_table_heartbeat_and_route #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptr_pkg::rsp_type rsp_data
);

   ptr_pkg::cmd_type cmd;
   ptr_pkg::sts_type sts;

   ptr_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .sts, .cmd
   );

   ptr_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_data
   );

endmodule

@@ verif/peer_table_heartbeat_and_route_tb.sv @@
`timescale 1ns / 1ps

module peer_table_heartbeat_and_route_tb;

   localparam int DEPTH = 64;
   localparam int LIMIT_CYCLES = 1000000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ptr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ptr_pkg::rsp_type rsp_data;

   peer_table_heartbeat_and_route #(.TABLE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // shadow copy of the peer table
   logic        peer_live [DEPTH];
   logic [63:0] peer_id [DEPTH][4];
   logic [63:0] peer_addr [DEPTH][2];
   logic [63:0] peer_seen [DEPTH];

   ptr_pkg::req_type pending_reqs[$];
   ptr_pkg::rsp_type expected_rsps[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      fail_count = 0;
   int      cycle_count = 0;

   // apply one transaction to the shadow table and return its result
   function automatic ptr_pkg::rsp_type table_update(ptr_pkg::req_type r);
      ptr_pkg::rsp_type o;
      logic [7:0] gap, best_gap;
      int         best;
      logic [63:0] w [4];
      o = '0;
      w[0] = r.id_word0; w[1] = r.id_word1; w[2] = r.id_word2; w[3] = r.id_word3;
      if (r.command == ptr_pkg::CMD_HEARTBEAT) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (peer_live[k] && peer_id[k][0] == w[0] && peer_id[k][1] == w[1] &&
                peer_id[k][2] == w[2] && peer_id[k][3] == w[3]) begin
               peer_seen[k] = r.time_ms;
               o.status = ptr_pkg::ST_REFRESHED;
               o.entry_index = k[5:0];
               return o;
            end
         end
         for (int k = 0; k < DEPTH; k++) begin
            if (!peer_live[k]) begin
               for (int j = 0; j < 4; j++) peer_id[k][j] = w[j];
               peer_addr[k][0] = r.addr_high;
               peer_addr[k][1] = r.addr_low;
               peer_seen[k] = r.time_ms;
               peer_live[k] = 1'b1;
               o.status = ptr_pkg::ST_INSERTED;
               o.entry_index = k[5:0];
               return o;
            end
         end
         o.status = ptr_pkg::ST_FULL;
         return o;
      end
      best = -1;
      best_gap = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (peer_live[k]) begin
            gap = peer_id[k][0][63:56] ^ r.id_word0[63:56];
            if (best < 0 || gap < best_gap) begin
               best = k;
               best_gap = gap;
            end
         end
      end
      if (best < 0) begin
         o.status = ptr_pkg::ST_NOROUTE;
         return o;
      end
      o.status = ptr_pkg::ST_ROUTE;
      o.entry_index = best[5:0];
      o.peer_word0 = peer_id[best][0];
      o.peer_word1 = peer_id[best][1];
      o.peer_word2 = peer_id[best][2];
      o.peer_word3 = peer_id[best][3];
      o.peer_addr_high = peer_addr[best][0];
      o.peer_addr_low = peer_addr[best][1];
      o.peer_seen_ms = peer_seen[best];
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // identities drawn from a small pool so that refreshes and ties are common
   logic [63:0] id_pool [16][4];

   function automatic ptr_pkg::req_type make_req(logic cmd, int pick, logic fresh);
      ptr_pkg::req_type r;
      r.command = cmd;
      if (fresh) begin
         r.id_word0 = rand64(); r.id_word1 = rand64();
         r.id_word2 = rand64(); r.id_word3 = rand64();
      end else begin
         r.id_word0 = id_pool[pick][0]; r.id_word1 = id_pool[pick][1];
         r.id_word2 = id_pool[pick][2]; r.id_word3 = id_pool[pick][3];
      end
      r.addr_high = rand64();
      r.addr_low = rand64();
      r.time_ms = rand64();
      return r;
   endfunction

   function automatic ptr_pkg::req_type near_miss(ptr_pkg::req_type r);
      // flip one bit of the identity outside the first byte
      case ($urandom_range(0, 3))
         0: r.id_word0[$urandom_range(0, 55)] ^= 1'b1;
         1: r.id_word1[$urandom_range(0, 63)] ^= 1'b1;
         2: r.id_word2[$urandom_range(0, 63)] ^= 1'b1;
         default: r.id_word3[$urandom_range(0, 63)] ^= 1'b1;
      endcase
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // prediction at acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_rsps.push_back(table_update(req_data));
   end

   // receiver stall and result check
   always @(posedge clock) begin
      ptr_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected transaction %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status ||
                   rsp_data.entry_index !== e.entry_index ||
                   rsp_data.peer_word0 !== e.peer_word0 ||
                   rsp_data.peer_word1 !== e.peer_word1 ||
                   rsp_data.peer_word2 !== e.peer_word2 ||
                   rsp_data.peer_word3 !== e.peer_word3 ||
                   rsp_data.peer_addr_high !== e.peer_addr_high ||
                   rsp_data.peer_addr_low !== e.peer_addr_low ||
                   rsp_data.peer_seen_ms !== e.peer_seen_ms) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      ptr_pkg::req_type r;
      int      kind;
      for (int k = 0; k < DEPTH; k++) peer_live[k] = 1'b0;
      for (int p = 0; p < 16; p++)
         for (int j = 0; j < 4; j++) id_pool[p][j] = rand64();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-table route, extremes, refresh, near miss, tie, full table
      pending_reqs.push_back(make_req(ptr_pkg::CMD_ROUTE, 0, 1'b1));
      r = '0;
      pending_reqs.push_back(r);
      r = '1;
      r.command = ptr_pkg::CMD_HEARTBEAT;
      pending_reqs.push_back(r);
      r.time_ms = 64'h0;
      pending_reqs.push_back(r);
      pending_reqs.push_back(near_miss(r));
      r = '1;
      pending_reqs.push_back(r);
      r = '0;
      r.command = ptr_pkg::CMD_ROUTE;
      pending_reqs.push_back(r);
      r.id_word0[63:56] = 8'h80;
      pending_reqs.push_back(r);
      for (int k = 0; k < DEPTH; k++)
         pending_reqs.push_back(make_req(ptr_pkg::CMD_HEARTBEAT, 0, 1'b1));
      pending_reqs.push_back(make_req(ptr_pkg::CMD_HEARTBEAT, 0, 1'b1));
      pending_reqs.push_back(make_req(ptr_pkg::CMD_ROUTE, 0, 1'b1));
      wait_drained();

      // random phases; reset happens once, so the table stays full from here on
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         for (int n = 0; n < 300; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4)
               r = make_req(ptr_pkg::CMD_HEARTBEAT, $urandom_range(0, 15), 1'b0);
            else if (kind < 5)
               r = make_req(ptr_pkg::CMD_HEARTBEAT, 0, 1'b1);
            else if (kind < 6)
               r = near_miss(make_req(ptr_pkg::CMD_HEARTBEAT, $urandom_range(0, 15), 1'b0));
            else
               r = make_req(ptr_pkg::CMD_ROUTE, 0, 1'b1);
            pending_reqs.push_back(r);
         end
         wait_drained();
      end

      repeat (2 * (DEPTH + 6)) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ peer_table_heartbeat_and_route.f @@
design/ptr_pkg.sv
design/ptr_datapath.sv
design/ptr_control.sv
design/peer_table_heartbeat_and_route.sv
verif/peer_table_heartbeat_and_route_tb.sv
